### hdl/bhic_pkg.sv
`timescale 1ns / 1ps

package bhic_pkg;

  // Field widths of one item and of the configuration port.
  localparam int unsigned KindW   = 3;
  localparam int unsigned KeyW    = 16;
  localparam int unsigned TargetW = 3;
  localparam int unsigned CmdW    = 2;
  localparam int unsigned TempW   = 12;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 7;
  localparam int unsigned SecW    = 32;
  localparam int unsigned StopW   = 7;

  // Blower stop counter value that means no delayed stop is pending.
  localparam logic [StopW-1:0] IDLE_STOP = 7'd127;
  localparam logic [5:0]       SECS_PER_MIN = 6'd60;

  // Key words. Each key has a short code and a bit-mask code.
  localparam logic [KeyW-1:0] KEY_LAMP      = 16'h0001;
  localparam logic [KeyW-1:0] KEY_LAMP_ALT  = 16'h0400;
  localparam logic [KeyW-1:0] KEY_VENT      = 16'h0002;
  localparam logic [KeyW-1:0] KEY_VENT_ALT  = 16'h0800;
  localparam logic [KeyW-1:0] KEY_ALL       = 16'h0003;
  localparam logic [KeyW-1:0] KEY_ALL_ALT   = 16'h1000;
  localparam logic [KeyW-1:0] KEY_H2        = 16'h0006;
  localparam logic [KeyW-1:0] KEY_H2_ALT    = 16'h0100;
  localparam logic [KeyW-1:0] KEY_AIR       = 16'h0007;
  localparam logic [KeyW-1:0] KEY_AIR_ALT   = 16'h0200;
  localparam logic [KeyW-1:0] KEY_H1        = 16'h0008;
  localparam logic [KeyW-1:0] KEY_H1_ALT    = 16'h0080;

  typedef enum logic [KindW-1:0] {
    KIND_TOUCH  = 3'd0,
    KIND_KEY    = 3'd1,
    KIND_REMOTE = 3'd2,
    KIND_TICK   = 3'd3,
    KIND_TEMP   = 3'd4
  } kind_e;

  typedef enum logic [TargetW-1:0] {
    TGT_LIGHT = 3'd0,
    TGT_VENT  = 3'd1,
    TGT_ALL   = 3'd2,
    TGT_H2    = 3'd3,
    TGT_BLOW  = 3'd4,
    TGT_H1    = 3'd5
  } target_e;

  typedef enum logic [CmdW-1:0] {
    CMD_OFF    = 2'd0,
    CMD_ON     = 2'd1,
    CMD_TOGGLE = 2'd2
  } command_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_DUAL_MOTOR   = 3'd0,
    REG_DUAL_HEATER  = 3'd1,
    REG_LINKAGE_MODE = 3'd2,
    REG_BLOWER_DELAY = 3'd3,
    REG_MAX_TEMP     = 3'd4,
    REG_HEAT_OFF_MIN = 3'd5,
    REG_VENT_OFF_MIN = 3'd6,
    REG_BEEP_ENABLE  = 3'd7
  } reg_e;

  // Linkage modes: which heaters drive the blower.
  localparam logic [1:0] LINK_NONE = 2'd0;
  localparam logic [1:0] LINK_ANY  = 2'd1;
  localparam logic [1:0] LINK_H1   = 2'd2;
  localparam logic [1:0] LINK_H2   = 2'd3;

endpackage

### hdl/bhic_if.sv
`timescale 1ns / 1ps

// Event item channel.
interface bhic_in_if import bhic_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [KindW-1:0]   kind;
  logic [KeyW-1:0]    key_code;
  logic [TargetW-1:0] target;
  logic [CmdW-1:0]    command;
  logic signed [TempW-1:0] temperature;

  modport source (output valid, kind, key_code, target, command, temperature, input ready);
  modport sink   (input valid, kind, key_code, target, command, temperature, output ready);
endinterface

// Result item channel.
interface bhic_out_if;
  logic valid;
  logic ready;
  logic light_on;
  logic vent_on;
  logic heater1_on;
  logic heater2_on;
  logic blower_on;
  logic all_off_mark;
  logic beep;
  logic refused;

  modport source (output valid, light_on, vent_on, heater1_on, heater2_on, blower_on,
                  all_off_mark, beep, refused, input ready);
  modport sink   (input valid, light_on, vent_on, heater1_on, heater2_on, blower_on,
                  all_off_mark, beep, refused, output ready);
endinterface

// Configuration write channel.
interface bhic_cfg_if import bhic_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [CfgDatW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### hdl/bath_heater_interlock_controller.sv
`timescale 1ns / 1ps

// Bath heater interlock controller.
// Each item on in_i is one event: a touch-key sample, a direct key, a remote
// command, a one-second tick or a temperature reading. Every item yields
// exactly one result item on out_o with the five load states after the event,
// the all-off mark, a beep request and the interlock refusal flag.
// Items are latched in an input register; the state update is a single pass
// of logic from that register into the state and result registers. The
// result item is registered once its item has passed the input register, and
// one item is taken per cycle as long as the result register drains; the
// result register is the only thing that holds the input side back.
// When out_o stalls, the pending result holds and one more item can wait in
// the input register; in_i.ready drops only when both are full.
// Configuration writes on cfg_i are always taken and should be issued only
// while no item is in flight.
// Reset clears all loads, the seconds count, both deadlines, the last touch
// sample and the all-off mark, idles the delayed blower stop and loads the
// default register values.
module bath_heater_interlock_controller
  import bhic_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  bhic_in_if.sink    in_i,
  bhic_out_if.source out_o,
  bhic_cfg_if.sink   cfg_i
);

  // Load and timer state that the switching rules act on.
  typedef struct packed {
    logic             light;
    logic             vent;
    logic             h1;
    logic             h2;
    logic             blow;
    logic [StopW-1:0] stop;
    logic [SecW-1:0]  vdl;
    logic [SecW-1:0]  hdl;
    logic             flag;
    logic             beep;
    logic             refused;
  } st_t;

  // Configuration and precomputed deadlines seen by the switching rules.
  typedef struct packed {
    logic             dm;
    logic             dh;
    logic [1:0]       lm;
    logic [StopW-1:0] dly;
    logic             be;
    logic             vom_nz;
    logic             hom_nz;
    logic [SecW-1:0]  vdl_new;
    logic [SecW-1:0]  hdl_new;
  } ctx_t;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_LIGHT,
    ACT_VENT,
    ACT_ALL,
    ACT_H2,
    ACT_BLOW,
    ACT_H1
  } act_e;

  // Blower switch, including the shared-motor ventilation stop.
  function automatic st_t f_blow_real(st_t s, ctx_t x, logic on, logic b);
    st_t r;
    r = s;
    if (s.blow != on) begin
      if (on && !x.dm && s.vent) begin
        r.vent = 1'b0;
        r.vdl  = '0;
      end
      r.blow = on;
      r.beep = r.beep | (b & x.be);
    end
    return r;
  endfunction

  // Ventilation switch with the single-motor interlock.
  function automatic st_t f_vent(st_t s, ctx_t x, logic on, logic b);
    st_t  r;
    logic blk;
    r   = s;
    blk = 1'b0;
    if (s.vent != on) begin
      if (on) begin
        blk = !x.dm && ((x.lm == LINK_ANY && (s.h1 || s.h2)) ||
                        (x.lm == LINK_H1 && s.h1) || (x.lm == LINK_H2 && s.h2) ||
                        (s.stop != IDLE_STOP));
        if (blk) begin
          r.refused = 1'b1;
        end else begin
          if (!x.dm) begin
            r = f_blow_real(r, x, 1'b0, 1'b0);
          end
          r.vent = 1'b1;
          if (x.vom_nz) begin
            r.vdl = x.vdl_new;
          end
        end
      end else begin
        r.vent = 1'b0;
        r.vdl  = '0;
      end
      r.beep = r.beep | (b & x.be);
    end
    return r;
  endfunction

  // Heater one switch with blower linkage and the heat deadline.
  function automatic st_t f_heat1(st_t s, ctx_t x, logic on, logic b);
    st_t r;
    r = s;
    if (s.h1 != on) begin
      if (on) begin
        if (x.lm == LINK_ANY || x.lm == LINK_H1) begin
          r = f_blow_real(r, x, 1'b1, 1'b0);
        end
        r.h1   = 1'b1;
        r.stop = IDLE_STOP;
        if (r.hdl == '0 && x.hom_nz) begin
          r.hdl = x.hdl_new;
        end
      end else begin
        r.h1 = 1'b0;
        if ((x.lm == LINK_ANY && !r.h2) || x.lm == LINK_H1) begin
          r.stop = x.dly;
        end
        if (!r.h2) begin
          r.hdl = '0;
        end
      end
      r.beep = r.beep | (b & x.be);
    end
    return r;
  endfunction

  // Heater two switch; with a single heater, heater one follows it.
  function automatic st_t f_heat2(st_t s, ctx_t x, logic on, logic b);
    st_t r;
    r = s;
    if (s.h2 != on) begin
      if (on) begin
        if (x.lm == LINK_ANY || x.lm == LINK_H2) begin
          r = f_blow_real(r, x, 1'b1, 1'b0);
        end
        r.h2   = 1'b1;
        r.stop = IDLE_STOP;
        if (r.hdl == '0 && x.hom_nz) begin
          r.hdl = x.hdl_new;
        end
      end else begin
        r.h2 = 1'b0;
        if ((x.lm == LINK_ANY && !r.h1) || x.lm == LINK_H2) begin
          r.stop = x.dly;
        end
        if (!r.h1) begin
          r.hdl = '0;
        end
      end
      r.beep = r.beep | (b & x.be);
      if (!x.dh) begin
        r = f_heat1(r, x, on, 1'b0);
      end
    end
    return r;
  endfunction

  // User blower request. Switching off also drops the linked heaters and is
  // ignored while a delayed stop is running.
  function automatic st_t f_blow(st_t s, ctx_t x, logic on, logic b);
    st_t r;
    r = s;
    if (on) begin
      r = f_blow_real(s, x, 1'b1, b);
    end else if (s.stop == IDLE_STOP) begin
      if (x.lm == LINK_ANY || x.lm == LINK_H1) begin
        r = f_heat1(r, x, 1'b0, 1'b0);
      end
      if (x.lm == LINK_ANY || x.lm == LINK_H2) begin
        r = f_heat2(r, x, 1'b0, 1'b0);
      end
      if (x.lm == LINK_NONE || r.stop == IDLE_STOP) begin
        r = f_blow_real(r, x, 1'b0, 1'b0);
      end
      r.beep = r.beep | (b & x.be);
    end
    return r;
  endfunction

  // Configuration registers.
  logic             dual_motor_q, dual_heater_q, beep_enable_q;
  logic [1:0]       linkage_mode_q;
  logic [StopW-1:0] blower_delay_q;
  logic [5:0]       max_temp_q;
  logic [6:0]       heat_off_min_q, vent_off_min_q;

  // Input register.
  logic                    in_vld_q;
  logic [KindW-1:0]        kind_q;
  logic [KeyW-1:0]         key_q;
  logic [TargetW-1:0]      target_q;
  logic [CmdW-1:0]         cmd_q;
  logic signed [TempW-1:0] temp_q;

  // Block state.
  st_t             st_q, st_d;
  logic [KeyW-1:0] last_key_q, last_key_d;
  logic [SecW-1:0] seconds_q, seconds_d;

  // Result register.
  logic out_vld_q;
  logic res_light_q, res_vent_q, res_h1_q, res_h2_q, res_blow_q;
  logic res_flag_q, res_beep_q, res_refused_q;

  logic            advance, in_accept;
  ctx_t            ctx;
  logic [12:0]     vent_span, heat_span;
  logic [SecW-1:0] sec_inc;
  logic            vdl_due, hdl_due, too_hot;
  logic [9:0]      max_tenths;
  act_e            act;
  logic            act_on, act_cur, do_act, is_remote;

  assign advance   = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || advance;
  assign in_accept = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  // Deadline spans, the timer comparisons and the temperature limit, done once per item.
  assign vent_span  = {6'd0, vent_off_min_q} * {7'd0, SECS_PER_MIN};
  assign heat_span  = {6'd0, heat_off_min_q} * {7'd0, SECS_PER_MIN};
  assign sec_inc    = seconds_q + 32'd1;
  assign vdl_due    = (st_q.vdl != '0) && (st_q.vdl <= sec_inc);
  assign hdl_due    = (st_q.hdl != '0) && (st_q.hdl <= sec_inc);
  assign max_tenths = {1'b0, max_temp_q, 3'd0} + {3'd0, max_temp_q, 1'b0};
  assign too_hot    = $signed({temp_q[TempW-1], temp_q}) >= $signed({3'd0, max_tenths});

  always_comb begin
    ctx.dm      = dual_motor_q;
    ctx.dh      = dual_heater_q;
    ctx.lm      = linkage_mode_q;
    ctx.dly     = blower_delay_q;
    ctx.be      = beep_enable_q;
    ctx.vom_nz  = vent_off_min_q != 7'd0;
    ctx.hom_nz  = heat_off_min_q != 7'd0;
    ctx.vdl_new = seconds_q + {19'd0, vent_span};
    ctx.hdl_new = seconds_q + {19'd0, heat_span};
  end

  // Decode the action named by a key word or a remote target.
  always_comb begin
    act       = ACT_NONE;
    is_remote = kind_q == KIND_REMOTE;
    do_act    = 1'b0;
    if (is_remote) begin
      do_act = 1'b1;
      unique case (target_q)
        TGT_LIGHT: act = ACT_LIGHT;
        TGT_VENT:  act = ACT_VENT;
        TGT_ALL:   act = ACT_ALL;
        TGT_H2:    act = ACT_H2;
        TGT_BLOW:  act = ACT_BLOW;
        TGT_H1:    act = ACT_H1;
        default:   act = ACT_NONE;
      endcase
    end else begin
      do_act = (kind_q == KIND_KEY) || (kind_q == KIND_TOUCH && key_q != last_key_q);
      unique case (key_q) inside
        KEY_LAMP, KEY_LAMP_ALT:   act = ACT_LIGHT;
        KEY_VENT, KEY_VENT_ALT:   act = ACT_VENT;
        KEY_ALL, KEY_ALL_ALT:     act = ACT_ALL;
        KEY_H2, KEY_H2_ALT:       act = ACT_H2;
        KEY_AIR, KEY_AIR_ALT:     act = ACT_BLOW;
        KEY_H1, KEY_H1_ALT:       act = ACT_H1;
        default:                  act = ACT_NONE;
      endcase
    end
  end

  // Requested state of the named load: keys toggle, remotes set or toggle.
  always_comb begin
    case (act)
      ACT_LIGHT: act_cur = st_q.light;
      ACT_VENT:  act_cur = st_q.vent;
      ACT_H2:    act_cur = st_q.h2;
      ACT_BLOW:  act_cur = st_q.blow;
      ACT_H1:    act_cur = st_q.h1;
      default:   act_cur = 1'b0;
    endcase
    if (is_remote && cmd_q == CMD_OFF) begin
      act_on = 1'b0;
    end else if (is_remote && cmd_q == CMD_ON) begin
      act_on = 1'b1;
    end else begin
      act_on = !act_cur;
    end
  end

  // One pass of the switching rules for the item in the input register.
  always_comb begin
    st_d         = st_q;
    st_d.beep    = 1'b0;
    st_d.refused = 1'b0;
    last_key_d   = last_key_q;
    seconds_d    = seconds_q;

    if (kind_q == KIND_TOUCH) begin
      last_key_d = key_q;
    end

    if (do_act) begin
      case (act)
        ACT_LIGHT: begin
          if (st_d.light != act_on) begin
            st_d.light = act_on;
            st_d.beep  = beep_enable_q;
          end
        end
        ACT_VENT: st_d = f_vent(st_d, ctx, act_on, 1'b1);
        ACT_ALL: begin
          st_d.flag  = 1'b1;
          st_d.light = 1'b0;
          st_d = f_vent(st_d, ctx, 1'b0, 1'b0);
          st_d = f_blow(st_d, ctx, 1'b0, 1'b0);
          st_d = f_heat1(st_d, ctx, 1'b0, 1'b0);
          st_d = f_heat2(st_d, ctx, 1'b0, 1'b0);
          st_d.beep = st_d.beep | beep_enable_q;
        end
        ACT_H2:   st_d = f_heat2(st_d, ctx, act_on, 1'b1);
        ACT_BLOW: st_d = f_blow(st_d, ctx, act_on, 1'b1);
        ACT_H1:   st_d = f_heat1(st_d, ctx, act_on, 1'b1);
        default:  st_d = st_d;
      endcase
    end

    // Second tick: delayed blower stop first, then the auto-off deadlines.
    if (kind_q == KIND_TICK) begin
      seconds_d = sec_inc;
      st_d.flag = 1'b0;
      if (st_q.stop != IDLE_STOP) begin
        if (st_q.stop <= 7'd1) begin
          st_d.stop = IDLE_STOP;
          st_d = f_blow_real(st_d, ctx, 1'b0, 1'b1);
        end else begin
          st_d.stop = st_q.stop - 7'd1;
        end
      end
      if (vdl_due) begin
        st_d.vdl = '0;
        st_d = f_vent(st_d, ctx, 1'b0, 1'b1);
      end
      if (hdl_due) begin
        st_d.hdl = '0;
        st_d = f_heat1(st_d, ctx, 1'b0, 1'b1);
        st_d = f_heat2(st_d, ctx, 1'b0, 1'b1);
      end
    end

    // Over-temperature cut-off.
    if (kind_q == KIND_TEMP && too_hot) begin
      st_d = f_heat1(st_d, ctx, 1'b0, 1'b1);
      st_d = f_heat2(st_d, ctx, 1'b0, 1'b1);
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dual_motor_q   <= 1'b1;
      dual_heater_q  <= 1'b1;
      linkage_mode_q <= LINK_ANY;
      blower_delay_q <= 7'd30;
      max_temp_q     <= 6'd40;
      heat_off_min_q <= 7'd30;
      vent_off_min_q <= 7'd30;
      beep_enable_q  <= 1'b1;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_DUAL_MOTOR:   dual_motor_q   <= cfg_i.data[0];
        REG_DUAL_HEATER:  dual_heater_q  <= cfg_i.data[0];
        REG_LINKAGE_MODE: linkage_mode_q <= cfg_i.data[1:0];
        REG_BLOWER_DELAY: blower_delay_q <= cfg_i.data;
        REG_MAX_TEMP:     max_temp_q     <= cfg_i.data[5:0];
        REG_HEAT_OFF_MIN: heat_off_min_q <= cfg_i.data;
        REG_VENT_OFF_MIN: vent_off_min_q <= cfg_i.data;
        REG_BEEP_ENABLE:  beep_enable_q  <= cfg_i.data[0];
        default:          beep_enable_q  <= beep_enable_q;
      endcase
    end
  end

  // Input register and its valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_accept) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      kind_q   <= in_i.kind;
      key_q    <= in_i.key_code;
      target_q <= in_i.target;
      cmd_q    <= in_i.command;
      temp_q   <= in_i.temperature;
    end
  end

  // State update, committed when the item moves into the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.light   <= 1'b0;
      st_q.vent    <= 1'b0;
      st_q.h1      <= 1'b0;
      st_q.h2      <= 1'b0;
      st_q.blow    <= 1'b0;
      st_q.stop    <= IDLE_STOP;
      st_q.vdl     <= '0;
      st_q.hdl     <= '0;
      st_q.flag    <= 1'b0;
      st_q.beep    <= 1'b0;
      st_q.refused <= 1'b0;
      last_key_q   <= '0;
      seconds_q    <= '0;
    end else if (advance) begin
      st_q       <= st_d;
      last_key_q <= last_key_d;
      seconds_q  <= seconds_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_light_q   <= st_d.light;
      res_vent_q    <= st_d.vent;
      res_h1_q      <= st_d.h1;
      res_h2_q      <= st_d.h2;
      res_blow_q    <= st_d.blow;
      res_flag_q    <= st_d.flag;
      res_beep_q    <= st_d.beep;
      res_refused_q <= st_d.refused;
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.light_on     = res_light_q;
  assign out_o.vent_on      = res_vent_q;
  assign out_o.heater1_on   = res_h1_q;
  assign out_o.heater2_on   = res_h2_q;
  assign out_o.blower_on    = res_blow_q;
  assign out_o.all_off_mark = res_flag_q;
  assign out_o.beep         = res_beep_q;
  assign out_o.refused      = res_refused_q;

endmodule
